>>> design/tawas_pkg.sv
// Shared constants, widths and the controller-to-datapath command bundle
// for the three-axis window average smoother. No dependencies.
package tawas_pkg;

    localparam int WINDOW   = 8;
    localparam int AXES     = 3;
    localparam int SAMPLE_W = 16;
    localparam int FILT_W   = 24;
    localparam int FRAC_W   = 8;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W    = SAMPLE_W + CNT_W;
    localparam int DVD_W    = SUM_W + FRAC_W;
    localparam int BIT_W    = $clog2(DVD_W);
    localparam int AXIS_W   = 2;
    localparam int WORD_W   = AXES * SAMPLE_W;

    typedef struct packed {
        logic              load;
        logic              update;
        logic              div_init;
        logic              div_step;
        logic              div_finish;
        logic              publish;
        logic [AXIS_W-1:0] axis;
    } t_cmd;

endpackage

>>> design/tawas_ctrl.sv
// Sequencer for the smoother: input/output handshakes and division steps.
// Depends on tawas_pkg; drives the datapath through t_cmd.
module tawas_ctrl import tawas_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV_INIT,
        S_DIV_RUN,
        S_FINISH,
        S_PUBLISH
    } t_state;

    t_state            r_state, n_state;
    logic [AXIS_W-1:0] r_axis, n_axis;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic              r_in_stall, n_in_stall;
    logic              r_out_valid, n_out_valid;
    logic              w_in_xfer;
    logic              w_out_free;

    assign w_in_xfer  = i_valid && !r_in_stall && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_bit       = r_bit;
        n_in_stall  = r_in_stall;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.axis  = r_axis;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    o_cmd.load = 1'b1;
                    n_in_stall = 1'b1;
                    n_state    = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_axis       = '0;
                n_state      = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_bit          = BIT_W'(DVD_W - 1);
                n_state        = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                o_cmd.div_step = 1'b1;
                if (r_bit == '0) begin
                    n_state = S_FINISH;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_FINISH: begin
                o_cmd.div_finish = 1'b1;
                if (r_axis == AXIS_W'(AXES - 1)) begin
                    n_state = S_PUBLISH;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_DIV_INIT;
                end
            end
            S_PUBLISH: begin
                if (w_out_free) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_in_stall    = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= '0;
            r_bit       <= '0;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_bit       <= n_bit;
            r_in_stall  <= n_in_stall;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = r_in_stall;
    assign o_valid = r_out_valid;

endmodule

>>> design/tawas_dp.sv
// Datapath: sample window memory, running sums, shared restoring divider,
// smoothing registers and output register. Depends on tawas_pkg.
module tawas_dp import tawas_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_x_sample,
    input  logic signed [SAMPLE_W-1:0] i_y_sample,
    input  logic signed [SAMPLE_W-1:0] i_z_sample,
    output logic signed [FILT_W-1:0]   o_x_filtered,
    output logic signed [FILT_W-1:0]   o_y_filtered,
    output logic signed [FILT_W-1:0]   o_z_filtered
);

    logic [WORD_W-1:0]         r_mem [WINDOW];
    logic [WORD_W-1:0]         r_rd;
    logic [WORD_W-1:0]         r_new;
    logic [SLOT_W-1:0]         r_slot, n_slot;
    logic                      r_full, n_full;
    logic [CNT_W-1:0]          r_count, n_count;
    logic signed [SUM_W-1:0]   r_sum [AXES];
    logic signed [SUM_W-1:0]   n_sum [AXES];
    logic signed [FILT_W-1:0]  r_smooth [AXES];
    logic                      r_started;
    logic [DVD_W-1:0]          r_dvd, n_dvd;
    logic [CNT_W-1:0]          r_rem, n_rem;
    logic                      r_neg;
    logic signed [SUM_W-1:0]   w_sum_sel;
    logic [SUM_W-1:0]          w_mag;
    logic [CNT_W:0]            w_rem_sh;
    logic [CNT_W:0]            w_rem_sub;
    logic                      w_ge;
    logic [DVD_W-1:0]          w_q_full;
    logic signed [FILT_W-1:0]  w_q;
    logic signed [FILT_W-1:0]  w_s_sel;
    logic signed [FILT_W:0]    w_s_add;
    logic signed [FILT_W-1:0]  n_smooth;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_sum[a] = r_sum[a]
                + SUM_W'($signed(r_new[a*SAMPLE_W +: SAMPLE_W]))
                - (r_full ? SUM_W'($signed(r_rd[a*SAMPLE_W +: SAMPLE_W])) : '0);
        end
        if (r_slot == SLOT_W'(WINDOW - 1)) begin
            n_slot = '0;
            n_full = 1'b1;
        end else begin
            n_slot = r_slot + 1'b1;
            n_full = r_full;
        end
        n_count = n_full ? CNT_W'(WINDOW) : CNT_W'(n_slot);
    end

    // divider: magnitude of sum << FRAC_W over the held-sample count
    assign w_sum_sel = r_sum[i_cmd.axis];
    assign w_mag     = w_sum_sel[SUM_W-1] ? SUM_W'(-w_sum_sel) : SUM_W'(w_sum_sel);
    assign w_rem_sh  = {r_rem, r_dvd[DVD_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_count};
    assign w_ge      = (w_rem_sh >= {1'b0, r_count});
    assign n_rem     = w_ge ? w_rem_sub[CNT_W-1:0] : w_rem_sh[CNT_W-1:0];
    assign n_dvd     = {r_dvd[DVD_W-2:0], w_ge};

    // truncation toward zero: divide magnitudes, then restore the sign
    assign w_q_full  = r_neg ? (~r_dvd + 1'b1) : r_dvd;
    assign w_q       = $signed(w_q_full[FILT_W-1:0]);
    assign w_s_sel   = r_smooth[i_cmd.axis];
    assign w_s_add   = {w_q[FILT_W-1], w_q} + {w_s_sel[FILT_W-1], w_s_sel};
    assign n_smooth  = r_started ? $signed(w_s_add[FILT_W:1]) : w_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd  <= r_mem[r_slot];
            r_new <= {i_z_sample, i_y_sample, i_x_sample};
        end
        if (i_cmd.update) begin
            r_mem[r_slot] <= r_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_dvd <= {w_mag, FRAC_W'(0)};
            r_rem <= '0;
            r_neg <= w_sum_sel[SUM_W-1];
        end else if (i_cmd.div_step) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
        if (i_cmd.publish) begin
            o_x_filtered <= r_smooth[0];
            o_y_filtered <= r_smooth[1];
            o_z_filtered <= r_smooth[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_full    <= 1'b0;
            r_count   <= CNT_W'(1);
            r_started <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_sum[a]    <= '0;
                r_smooth[a] <= '0;
            end
        end else begin
            if (i_cmd.update) begin
                r_slot  <= n_slot;
                r_full  <= n_full;
                r_count <= n_count;
                for (int a = 0; a < AXES; a++) begin
                    r_sum[a] <= n_sum[a];
                end
            end
            if (i_cmd.div_finish) begin
                r_smooth[i_cmd.axis] <= n_smooth;
            end
            if (i_cmd.publish) begin
                r_started <= 1'b1;
            end
        end
    end

endmodule

>>> design/three_axis_window_average_smoother.sv
// Three-axis window average smoother, top level.
// Depends on tawas_pkg, tawas_ctrl and tawas_dp.
//
// Input channel: i_valid / o_stall carry one X/Y/Z sample triple per
// transfer. Output channel: o_valid / i_stall carry the three smoothed
// averages (signed, 8 fractional bits) per transfer; one result per input.
// Each axis keeps the last WINDOW samples and a running sum; the average
// divides that sum (scaled by 256) by the number of samples held, using one
// restoring divider shared by the three axes, one quotient bit per cycle.
// o_stall rises with the input transfer and stays high until the result is
// handed off to the output register, dropping as o_valid rises, so a new
// sample triple is taken only after the last one has been handed off: the
// divider loop sets the sustained rate.
// The result sits in an output register: while the receiver stalls, the
// next sample is still taken and processed, and only its hand-off to the
// output register waits for the earlier result to leave.
// Synchronous active-low reset empties the window, clears the sums and the
// smoothing history, and drops o_valid; the first result after reset is
// seeded directly from its average.
module three_axis_window_average_smoother import tawas_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_x_sample,
    input  logic signed [SAMPLE_W-1:0] i_y_sample,
    input  logic signed [SAMPLE_W-1:0] i_z_sample,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [FILT_W-1:0]   o_x_filtered,
    output logic signed [FILT_W-1:0]   o_y_filtered,
    output logic signed [FILT_W-1:0]   o_z_filtered
);

    t_cmd w_cmd;

    tawas_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    tawas_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_x_sample   (i_x_sample),
        .i_y_sample   (i_y_sample),
        .i_z_sample   (i_z_sample),
        .o_x_filtered (o_x_filtered),
        .o_y_filtered (o_y_filtered),
        .o_z_filtered (o_z_filtered)
    );

    a_in_xfer_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken without raising stall");

    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.publish |-> (!o_valid || !i_stall))
        else $error("result overwrote a pending output");

    a_valid_from_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.publish))
        else $error("output valid without a published result");

    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_step |-> o_stall)
        else $error("divider running while input open");

endmodule

>>> dv/tb.sv
// Self-checking testbench for three_axis_window_average_smoother: random and directed
// sample transfers, an in-bench window average and smoothing predictor, and a result scoreboard.
// Depends on tawas_pkg and the RTL under design/.
module tb;
    import tawas_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_ITEMS = 1026;
    localparam int DRAIN_CYCLES = 150;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
    } t_accel;

    typedef struct {
        logic [FILT_W-1:0] x;
        logic [FILT_W-1:0] y;
        logic [FILT_W-1:0] z;
    } t_filt;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_valid    = 1'b0;
    logic                       i_stall    = 1'b0;
    logic signed [SAMPLE_W-1:0] i_x_sample = '0;
    logic signed [SAMPLE_W-1:0] i_y_sample = '0;
    logic signed [SAMPLE_W-1:0] i_z_sample = '0;
    logic                       o_stall;
    logic                       o_valid;
    logic signed [FILT_W-1:0]   o_x_filtered;
    logic signed [FILT_W-1:0]   o_y_filtered;
    logic signed [FILT_W-1:0]   o_z_filtered;

    three_axis_window_average_smoother uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_x_sample   (i_x_sample),
        .i_y_sample   (i_y_sample),
        .i_z_sample   (i_z_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_x_filtered (o_x_filtered),
        .o_y_filtered (o_y_filtered),
        .o_z_filtered (o_z_filtered)
    );

    t_accel sample_q[$];
    t_filt  filtered_q[$];

    // predictor state
    longint hist[3][WINDOW];
    longint win_sum[3];
    longint smooth_acc[3];
    int     wr_slot    = 0;
    bit     win_full   = 1'b0;
    bit     seeded     = 1'b0;

    int in_issued   = 0;
    int in_done     = 0;
    int out_done    = 0;
    int mismatches  = 0;
    int idle_cycles = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_filt predict_smoothed(t_accel s);
        longint nv[3];
        longint avg;
        int     cnt;
        t_filt  r;
        nv[0] = s.x;
        nv[1] = s.y;
        nv[2] = s.z;
        for (int a = 0; a < 3; a++) begin
            if (win_full)
                win_sum[a] -= hist[a][wr_slot];
            hist[a][wr_slot] = nv[a];
            win_sum[a] += nv[a];
        end
        wr_slot = (wr_slot + 1) % WINDOW;
        if (wr_slot == 0)
            win_full = 1'b1;
        cnt = win_full ? WINDOW : wr_slot;
        for (int a = 0; a < 3; a++) begin
            avg = (win_sum[a] * 256) / cnt;
            smooth_acc[a] = seeded ? ((smooth_acc[a] + avg) >>> 1) : avg;
        end
        seeded = 1'b1;
        r.x = smooth_acc[0][FILT_W-1:0];
        r.y = smooth_acc[1][FILT_W-1:0];
        r.z = smooth_acc[2][FILT_W-1:0];
        return r;
    endfunction

    function automatic int pick_idle();
        int r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 96)
            return $urandom_range(5, 40);
        return $urandom_range(100, 300);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_axis();
        int r = $urandom_range(0, 99);
        if (r < 12) begin
            case ($urandom_range(0, 3))
                0: return SAMPLE_W'(-32768);
                1: return SAMPLE_W'(32767);
                2: return SAMPLE_W'(0);
                default: return SAMPLE_W'(-1);
            endcase
        end
        if (r < 35)
            return SAMPLE_W'($signed($urandom_range(0, 31)) - 16);
        return SAMPLE_W'($urandom());
    endfunction

    task automatic add_sample(int x, int y, int z);
        t_accel s;
        s.x = SAMPLE_W'(x);
        s.y = SAMPLE_W'(y);
        s.z = SAMPLE_W'(z);
        sample_q.push_back(s);
    endtask

    // driver and output stall generator
    int calm_left  = 0;
    bit calm       = 1'b0;
    int gap_left   = 0;
    int stall_left = 0;

    always @(negedge i_clk) begin
        t_accel s;
        if (i_rst_n) begin
            if (calm_left == 0) begin
                calm = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(50, 400);
            end else begin
                calm_left--;
            end

            if (!i_valid || in_done == in_issued) begin
                if (i_valid)
                    gap_left = calm ? 0 : pick_idle();
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    s = sample_q.pop_front();
                    i_x_sample <= s.x;
                    i_y_sample <= s.y;
                    i_z_sample <= s.z;
                    i_valid <= 1'b1;
                    in_issued++;
                end else begin
                    i_valid <= 1'b0;
                end
            end

            if (stall_left > 0) begin
                stall_left--;
            end else if (calm) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 2) == 0);
                stall_left = pick_idle();
            end
        end
    end

    // monitor, scoreboard and watchdog
    always @(posedge i_clk) begin
        t_filt e;
        bit    moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_valid && !o_stall) begin
                filtered_q.push_back(predict_smoothed('{i_x_sample, i_y_sample, i_z_sample}));
                in_done++;
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                out_done++;
                moved = 1'b1;
                if (filtered_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("ERROR: result transfer %0d with nothing expected", out_done);
                end else begin
                    e = filtered_q.pop_front();
                    if (o_x_filtered !== e.x || o_y_filtered !== e.y
                            || o_z_filtered !== e.z) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"ERROR: result %0d exp x=%0d y=%0d z=%0d",
                                      " got x=%0d y=%0d z=%0d"},
                                     out_done, $signed(e.x), $signed(e.y), $signed(e.z),
                                     o_x_filtered, o_y_filtered, o_z_filtered);
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
                $display("three_axis_window_average_smoother verification failed");
                $finish;
            end
        end
    end

    initial begin
        for (int a = 0; a < 3; a++) begin
            win_sum[a] = 0;
            smooth_acc[a] = 0;
            for (int k = 0; k < WINDOW; k++)
                hist[a][k] = 0;
        end

        // window filling from reset, then a full window at the positive extreme and alternating extremes
        add_sample(0, 0, 0);
        add_sample(-32768, 32767, -1);
        add_sample(32767, -32768, 1);
        repeat (5) add_sample(-32768, -32768, -32768);
        repeat (8) add_sample(32767, 32767, 32767);
        repeat (2) begin
            add_sample(-32768, 32767, -32768);
            add_sample(32767, -32768, 32767);
        end
        add_sample(-1, 1, -1);
        add_sample(16'sh5555, -21846, 16'sh5555);
        add_sample(-21846, 16'sh5555, -21846);
        add_sample(-3, -5, 7);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            add_sample(pick_axis(), pick_axis(), pick_axis());

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (sample_q.size() > 0 || in_done != in_issued || filtered_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d sample transfers and %0d result transfers,", in_done, out_done);
        $display("window fill from reset, full-scale extremes and random stalls; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
            $display("three_axis_window_average_smoother verification clean");
        else
            $display("three_axis_window_average_smoother verification failed");
        $finish;
    end

endmodule
